[rtl/core/rhp_pkg.sv]
// Shared types and constants for the RGB to HSV pixel converter.
package rhp_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned HUE_W    = 9;
    localparam int unsigned N_CELLS  = CHAN_W;

    localparam logic [5:0]       HUE_SCALE  = 6'd60;
    localparam logic [HUE_W-1:0] HUE_FULL   = 9'd360;
    localparam logic [HUE_W-1:0] GREEN_BASE = 9'd120;
    localparam logic [HUE_W-1:0] BLUE_BASE  = 9'd240;

    typedef enum logic [1:0] {
        SECTOR_RED   = 2'd0,
        SECTOR_GREEN = 2'd1,
        SECTOR_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic [CHAN_W-1:0] part;
        logic [CHAN_W-1:0] shift;
        logic [CHAN_W-1:0] divisor;
    } lane_t;

    typedef struct packed {
        sector_t           sector;
        logic              neg;
        logic              hue_zero;
        logic              sat_zero;
        logic [CHAN_W-1:0] value;
    } tag_t;

    typedef struct packed {
        logic  valid;
        tag_t  tag;
        lane_t hue;
        lane_t sat;
    } stage_t;

endpackage

[rtl/core/rgb_to_hsv_pixel.sv]
// RGB to HSV pixel converter, top level.
// Input: drive rgb_word (red 23:16, green 15:8, blue 7:0) with start high;
// the item is taken at the clock edge where start is high and busy is low.
// busy stays low, so a new pixel may be given on every clock.
// Output: done is high for one cycle with hue_deg (0..359), saturation
// (255 * delta / max, truncated) and brightness (max) on the ports.
// Pipeline: each item passes through the divider row in order: one input
// register, eight restoring division cells (one quotient bit each, hue and
// saturation in parallel lanes) and one output register, which drives the
// ports; throughput is one pixel per clock.
// Results cannot be held off by the receiver; items move on every clock
// and each result is shown exactly once.
// Reset (rst_n low, asynchronous) clears all valid flags, dropping any
// items in flight; done stays low until a new item has passed the row.
module rgb_to_hsv_pixel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [23:0] rgb_word,
    output logic        done,
    output logic [8:0]  hue_deg,
    output logic [7:0]  saturation,
    output logic [7:0]  brightness
);

    rhp_pkg::stage_t stage [0:rhp_pkg::N_CELLS];

    assign busy = 1'b0;

    rhp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (start && !busy),
        .rgb_word  (rgb_word),
        .stage_out (stage[0])
    );

    for (genvar i = 0; i < rhp_pkg::N_CELLS; i++)
    begin : g_cell
        rhp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (stage[i]),
            .stage_out (stage[i+1])
        );
    end

    rhp_hue_fix u_hue_fix (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage_in   (stage[rhp_pkg::N_CELLS]),
        .done       (done),
        .hue_deg    (hue_deg),
        .saturation (saturation),
        .brightness (brightness)
    );

endmodule

[rtl/core/rhp_front.sv]
// Input stage: component split, max/min, sector select and divider setup.
module rhp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [23:0]          rgb_word,
    output rhp_pkg::stage_t      stage_out
);

    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  delta;
    logic [7:0]  pos_a;
    logic [7:0]  pos_b;
    logic [7:0]  mag;
    logic [13:0] hue_num;
    logic [15:0] sat_num;
    rhp_pkg::sector_t sector;
    rhp_pkg::stage_t  stage_next;
    logic             valid_reg;
    rhp_pkg::stage_t  stage_reg;

    assign r = rgb_word[23:16];
    assign g = rgb_word[15:8];
    assign b = rgb_word[7:0];

    always_comb
    begin
        priority if (r >= g && r >= b)
        begin
            sector = rhp_pkg::SECTOR_RED;
            mx     = r;
            pos_a  = g;
            pos_b  = b;
        end
        else if (g >= b)
        begin
            sector = rhp_pkg::SECTOR_GREEN;
            mx     = g;
            pos_a  = b;
            pos_b  = r;
        end
        else
        begin
            sector = rhp_pkg::SECTOR_BLUE;
            mx     = b;
            pos_a  = r;
            pos_b  = g;
        end
    end

    always_comb
    begin
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
    end

    assign delta   = mx - mn;
    assign mag     = (pos_a >= pos_b) ? (pos_a - pos_b) : (pos_b - pos_a);
    assign hue_num = 14'(mag) * 14'(rhp_pkg::HUE_SCALE);
    assign sat_num = {delta, 8'd0} - {8'd0, delta};

    always_comb
    begin
        stage_next.valid        = accept;
        stage_next.tag.sector   = sector;
        stage_next.tag.neg      = (pos_a < pos_b);
        stage_next.tag.hue_zero = (delta == 8'd0);
        stage_next.tag.sat_zero = (mx == 8'd0);
        stage_next.tag.value    = mx;
        stage_next.hue.part     = {2'b00, hue_num[13:8]};
        stage_next.hue.shift    = hue_num[7:0];
        stage_next.hue.divisor  = delta;
        stage_next.sat.part     = sat_num[15:8];
        stage_next.sat.shift    = sat_num[7:0];
        stage_next.sat.divisor  = mx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    always_comb
    begin
        stage_out       = stage_reg;
        stage_out.valid = valid_reg;
    end

endmodule

[rtl/core/rhp_div_cell.sv]
// One restoring division step for the hue and saturation lanes.
module rhp_div_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  rhp_pkg::stage_t  stage_in,
    output rhp_pkg::stage_t  stage_out
);

    function automatic rhp_pkg::lane_t div_step(input rhp_pkg::lane_t l);
        logic [8:0]     trial;
        logic [8:0]     diff;
        rhp_pkg::lane_t res;
        trial   = {l.part, l.shift[7]};
        diff    = trial - {1'b0, l.divisor};
        res     = l;
        if (trial >= {1'b0, l.divisor})
        begin
            res.part  = diff[7:0];
            res.shift = {l.shift[6:0], 1'b1};
        end
        else
        begin
            res.part  = trial[7:0];
            res.shift = {l.shift[6:0], 1'b0};
        end
        return res;
    endfunction

    rhp_pkg::stage_t stage_next;
    logic            valid_reg;
    rhp_pkg::stage_t stage_reg;

    always_comb
    begin
        stage_next     = stage_in;
        stage_next.hue = div_step(stage_in.hue);
        stage_next.sat = div_step(stage_in.sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    always_comb
    begin
        stage_out       = stage_reg;
        stage_out.valid = valid_reg;
    end

endmodule

[rtl/core/rhp_hue_fix.sv]
// Output stage: hue offset and rounding by sector, result registers.
module rhp_hue_fix (
    input  logic            clk,
    input  logic            rst_n,
    input  rhp_pkg::stage_t stage_in,
    output logic            done,
    output logic [8:0]      hue_deg,
    output logic [7:0]      saturation,
    output logic [7:0]      brightness
);

    logic [8:0] q9;
    logic [8:0] rem_nz;
    logic [8:0] hue_next;
    logic [7:0] sat_next;
    logic       done_reg;
    logic [8:0] hue_reg;
    logic [7:0] sat_reg;
    logic [7:0] bright_reg;

    assign q9     = {1'b0, stage_in.hue.shift};
    assign rem_nz = {8'd0, (stage_in.hue.part != 8'd0)};

    always_comb
    begin
        hue_next = 9'd0;
        if (!stage_in.tag.hue_zero)
        begin
            unique case (stage_in.tag.sector)
                rhp_pkg::SECTOR_RED:
                begin
                    hue_next = (stage_in.tag.neg && q9 != 9'd0) ? (rhp_pkg::HUE_FULL - q9) : q9;
                end
                rhp_pkg::SECTOR_GREEN:
                begin
                    hue_next = stage_in.tag.neg ? (rhp_pkg::GREEN_BASE - q9 - rem_nz)
                                                : (rhp_pkg::GREEN_BASE + q9);
                end
                rhp_pkg::SECTOR_BLUE:
                begin
                    hue_next = stage_in.tag.neg ? (rhp_pkg::BLUE_BASE - q9 - rem_nz)
                                                : (rhp_pkg::BLUE_BASE + q9);
                end
                default:
                begin
                    hue_next = 9'd0;
                end
            endcase
        end
    end

    assign sat_next = stage_in.tag.sat_zero ? 8'd0 : stage_in.sat.shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg    <= hue_next;
        sat_reg    <= sat_next;
        bright_reg <= stage_in.tag.value;
    end

    assign done       = done_reg;
    assign hue_deg    = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

[rtl/core/rhp_checker.sv]
// Port-level checks for the RGB to HSV pixel converter.
module rhp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [8:0] hue_deg,
    input logic [7:0] saturation,
    input logic [7:0] brightness
);

    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##10 done)
        else $error("accepted item gave no result on time");

    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 10))
        else $error("result without a matching item");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue_deg < 9'd360))
        else $error("hue out of range");

    a_hue_needs_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hue_deg != 9'd0) |-> (saturation != 8'd0))
        else $error("nonzero hue with zero saturation");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && brightness == 8'd0) |-> (saturation == 8'd0 && hue_deg == 9'd0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_pixel rhp_checker u_rhp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .hue_deg    (hue_deg),
    .saturation (saturation),
    .brightness (brightness)
);

[sim/testbench.sv]
// Self-checking testbench for the RGB to HSV pixel converter.
module testbench;

    typedef struct packed {
        logic [rhp_pkg::HUE_W-1:0]  hue;
        logic [rhp_pkg::CHAN_W-1:0] sat;
        logic [rhp_pkg::CHAN_W-1:0] val;
    } hsv_t;

    typedef struct packed {
        logic                       fixed;
        logic [23:0]                rgb;
        logic [rhp_pkg::HUE_W-1:0]  hue;
        logic [rhp_pkg::CHAN_W-1:0] sat;
        logic [rhp_pkg::CHAN_W-1:0] val;
    } pixel_row_t;

    typedef enum int {
        PX_ANY,
        PX_GREY,
        PX_TIE,
        PX_NEAR_GREY,
        PX_EDGE,
        PX_DIM
    } pixel_kind_t;

    localparam int N_ROWS    = 24;
    localparam int N_RANDOM  = 380;
    localparam int TAIL_WAIT = 20;

    localparam pixel_row_t DIRECTED [0:N_ROWS-1] = '{
        {1'b1, 24'h000000, 9'd0,   8'd0,   8'd0},
        {1'b1, 24'hFFFFFF, 9'd0,   8'd0,   8'd255},
        {1'b1, 24'h808080, 9'd0,   8'd0,   8'd128},
        {1'b1, 24'h010101, 9'd0,   8'd0,   8'd1},
        {1'b1, 24'hFF0000, 9'd0,   8'd255, 8'd255},
        {1'b1, 24'h00FF00, 9'd120, 8'd255, 8'd255},
        {1'b1, 24'h0000FF, 9'd240, 8'd255, 8'd255},
        {1'b1, 24'hFF0001, 9'd0,   8'd255, 8'd255},
        {1'b0, 24'hFFFF00, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'hFF00FF, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'h00FFFF, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'h010000, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'h000100, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'h000001, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'hFE01FF, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'h7F7F80, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'hFF7F00, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'hAA55AA, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'h55AA55, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'hC80A0B, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'h123456, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'hFEFEFF, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'h01FFFF, 9'd0,   8'd0,   8'd0},
        {1'b0, 24'hFF00FE, 9'd0,   8'd0,   8'd0}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [23:0]                rgb_word = 24'h000000;
    logic                       busy;
    logic                       done;
    logic [rhp_pkg::HUE_W-1:0]  hue_deg;
    logic [rhp_pkg::CHAN_W-1:0] saturation;
    logic [rhp_pkg::CHAN_W-1:0] brightness;

    hsv_t pending_hsv [$];
    hsv_t want;
    int   failures = 0;
    int   n_items = 0;
    int   n_checked = 0;
    int   n_grey = 0;
    int   n_tied = 0;

    rgb_to_hsv_pixel DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .rgb_word   (rgb_word),
        .done       (done),
        .hue_deg    (hue_deg),
        .saturation (saturation),
        .brightness (brightness)
    );

    always #5 clk = ~clk;

    function automatic hsv_t hsv_of(input logic [23:0] px);
        int   r;
        int   g;
        int   b;
        int   mx;
        int   mn;
        int   dl;
        int   h;
        int   s;
        hsv_t res;
        r = px[23:16];
        g = px[15:8];
        b = px[7:0];
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl = mx - mn;
        if (dl == 0)
            h = 0;
        else if (mx == r)
        begin
            h = (60 * (g - b)) / dl;
            if (h < 0)
                h = h + 360;
        end
        else if (mx == g)
            h = (120 * dl + 60 * (b - r)) / dl;
        else
            h = (240 * dl + 60 * (r - g)) / dl;
        s = (mx == 0) ? 0 : (255 * dl) / mx;
        res.hue = h[rhp_pkg::HUE_W-1:0];
        res.sat = s[rhp_pkg::CHAN_W-1:0];
        res.val = mx[rhp_pkg::CHAN_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    function automatic logic [7:0] edge_chan();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hFE;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [23:0] rand_pixel();
        pixel_kind_t kind;
        logic [7:0]  m;
        logic [7:0]  o;
        logic [7:0]  c;
        kind = pixel_kind_t'($urandom_range(PX_ANY, PX_DIM));
        case (kind)
            PX_GREY:
            begin
                c = 8'($urandom_range(0, 255));
                return {c, c, c};
            end
            PX_TIE:
            begin
                m = 8'($urandom_range(1, 255));
                o = 8'($urandom_range(0, m));
                case ($urandom_range(0, 2))
                    0: return {m, m, o};
                    1: return {m, o, m};
                    default: return {o, m, m};
                endcase
            end
            PX_NEAR_GREY:
            begin
                c = 8'($urandom_range(2, 253));
                return {c - 8'd2 + 8'($urandom_range(0, 4)),
                        c - 8'd2 + 8'($urandom_range(0, 4)),
                        c - 8'd2 + 8'($urandom_range(0, 4))};
            end
            PX_EDGE:
                return {edge_chan(), edge_chan(), edge_chan()};
            PX_DIM:
                return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                        8'($urandom_range(0, 3))};
            default:
                return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    task automatic send_pixel(input logic [23:0] px, input logic fixed, input hsv_t typed,
                              input int gap);
        start    <= 1'b1;
        rgb_word <= px;
        do
            @(posedge clk);
        while (busy);
        pending_hsv.push_back(fixed ? typed : hsv_of(px));
        n_items++;
        if (px[23:16] == px[15:8] && px[15:8] == px[7:0])
            n_grey++;
        else if (px[23:16] == px[15:8] || px[23:16] == px[7:0] || px[15:8] == px[7:0])
            n_tied++;
        if (gap > 0)
        begin
            start    <= 1'b0;
            rgb_word <= 24'($urandom_range(0, 24'hFFFFFF));
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_hsv.size() == 0)
            begin
                $error("result with no item outstanding: hue_deg %0d saturation %0d %s %0d",
                       hue_deg, saturation, "brightness", brightness);
                failures++;
            end
            else
            begin
                want = pending_hsv.pop_front();
                n_checked++;
                if (hue_deg !== want.hue)
                begin
                    $error("hue_deg: expected %0d, got %0d", want.hue, hue_deg);
                    failures++;
                end
                if (saturation !== want.sat)
                begin
                    $error("saturation: expected %0d, got %0d", want.sat, saturation);
                    failures++;
                end
                if (brightness !== want.val)
                begin
                    $error("brightness: expected %0d, got %0d", want.val, brightness);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        int   burst;
        hsv_t typed;
        burst = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_ROWS; i++)
        begin
            typed = {DIRECTED[i].hue, DIRECTED[i].sat, DIRECTED[i].val};
            send_pixel(DIRECTED[i].rgb, DIRECTED[i].fixed, typed, pick_gap());
        end
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (burst == 0 && $urandom_range(0, 19) == 0)
                burst = $urandom_range(10, 40);
            if (burst > 0)
            begin
                burst--;
                send_pixel(rand_pixel(), 1'b0, '0, 0);
            end
            else
                send_pixel(rand_pixel(), 1'b0, '0, pick_gap());
        end
        start <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        $display("Converted %0d pixels, %0d results checked (%0d grey, %0d tied).",
                 n_items, n_checked, n_grey, n_tied);
        $display("Directed extremes, ties and truncation cases ran ahead of random pixels.");
        if (failures == 0)
            $display("rgb_to_hsv_pixel test passed");
        else
            $display("rgb_to_hsv_pixel test failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("rgb_to_hsv_pixel test failed");
        $finish;
    end

endmodule
